// ===== design/xorshift32_ranged_random_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ranged xorshift32 generator
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT32_RANGED_RANDOM_MACROS_SVH
`define XORSHIFT32_RANGED_RANDOM_MACROS_SVH

`ifndef SYNTHESIS
// Implication or expression that must hold at every clock edge out of reset
`define XRR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("xorshift32_ranged_random: assertion failed");
// Condition that must never be seen out of reset
`define XRR_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("xorshift32_ranged_random: forbidden condition");
`else
`define XRR_ASSERT(lbl, clk, rstn, prop)
`define XRR_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== design/xrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Ranged xorshift32 generator package
// Widths, shift amounts, divider status type and the generator step.
// ----------------------------------------------------------------------------
package xrr_pkg;

	localparam int DATA_W  = 32;
	localparam int BOUND_W = DATA_W + 1;
	localparam int STEP_W  = $clog2(DATA_W);

	localparam int SHIFT_A = 13;
	localparam int SHIFT_B = 17;
	localparam int SHIFT_C = 5;

	// Remainder unit status seen by the control
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// One xorshift step: left, right, left
	function automatic logic [DATA_W-1:0] xrr_advance(input logic [DATA_W-1:0] s);
		logic [DATA_W-1:0] t;
		t = s ^ (s << SHIFT_A);
		t = t ^ (t >> SHIFT_B);
		t = t ^ (t << SHIFT_C);
		return t;
	endfunction

endpackage

// ===== design/xorshift32_ranged_random.sv =====
// ----------------------------------------------------------------------------
// Ranged xorshift32 random source
// A non-empty request loads the cell row, takes one remainder step per dividend
// bit and then fills the output register; an empty one goes straight to output.
// A request is stalled until the previous result has entered the output register.
// Reset clears the generator to zero and empties the output register.
// ----------------------------------------------------------------------------
`include "xorshift32_ranged_random_macros.svh"

module xorshift32_ranged_random (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [xrr_pkg::DATA_W-1:0] seed,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [xrr_pkg::DATA_W-1:0] range_low,
	input  logic signed [xrr_pkg::DATA_W-1:0] range_high,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [xrr_pkg::DATA_W-1:0] value
);
	import xrr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t              state_q;
	logic [DATA_W-1:0]   gen_q;
	logic [DATA_W-1:0]   gen_next;
	logic [DATA_W-1:0]   low_q;
	logic                empty_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   value_q;
	logic [BOUND_W-1:0]  diff;
	logic                empty;
	logic                in_acc;
	logic                cfg_acc;
	logic                out_free;
	logic                div_start;
	div_status_t         div_sts;
	logic [DATA_W-1:0]   rem;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	// Span minus one; empty when not positive
	assign diff  = {range_high[DATA_W-1], range_high} - {range_low[DATA_W-1], range_low};
	assign empty = diff[BOUND_W-1] | (diff == '0);

	assign gen_next  = xrr_advance(gen_q);
	assign div_start = in_acc & ~empty;

	xrr_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(gen_next),
		.bound   (diff),
		.sts     (div_sts),
		.rem     (rem)
	);

	// Generator: reload on seed write, advance on a non-empty request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (cfg_acc) begin
			gen_q <= seed;
		end else if (div_start) begin
			gen_q <= gen_next;
		end
	end

	// Hold the lower bound and the empty flag of the request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			low_q   <= range_low;
			empty_q <= empty;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= empty ? S_OUT : S_DIV;
					end
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			value_q <= low_q + (empty_q ? '0 : rem);
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Checks
	`XRR_ASSERT(a_empty_keeps_gen, clk, arst_n,
		(in_acc && empty && !cfg_acc) |=> (gen_q == $past(gen_q)))
	`XRR_ASSERT(a_done_in_div, clk, arst_n, div_sts.done |-> (state_q == S_DIV))
	`XRR_ASSERT(a_div_busy, clk, arst_n, (state_q == S_DIV) |-> div_sts.busy)
	`XRR_ASSERT(a_result_from_out, clk, arst_n,
		(out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_OUT))
	`XRR_NEVER(a_no_start_busy, clk, arst_n, div_start && div_sts.busy)

endmodule

// ===== design/xrr_cell.sv =====
// ----------------------------------------------------------------------------
// Remainder cell
// Holds one bit of the partial remainder and of the bound, forms one bit of
// the trial subtraction and passes its remainder bit to the next cell.
// ----------------------------------------------------------------------------
module xrr_cell (
	input  logic clk,
	input  logic load,
	input  logic step,
	input  logic shift_in,
	input  logic bound_in,
	input  logic borrow_in,
	input  logic take,
	output logic r,
	output logic borrow_out
);

	logic r_q;
	logic d_q;
	logic dif;

	// Trial subtract one bit
	assign dif        = shift_in ^ d_q ^ borrow_in;
	assign borrow_out = (~shift_in & d_q) | (~(shift_in ^ d_q) & borrow_in);
	assign r          = r_q;

	// Clear on load, then keep either the difference or the shifted bit
	always_ff @(posedge clk) begin
		if (load) begin
			r_q <= 1'b0;
			d_q <= bound_in;
		end else if (step) begin
			r_q <= take ? dif : shift_in;
		end
	end

endmodule

// ===== design/xrr_divider.sv =====
// ----------------------------------------------------------------------------
// Serial remainder unit
// Row of cells doing restoring division, one dividend bit per cycle. The bound
// held is span - 1, so the chain enters with a borrow and subtracts the span.
// ----------------------------------------------------------------------------
module xrr_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [xrr_pkg::DATA_W-1:0]  dividend,
	input  logic [xrr_pkg::BOUND_W-1:0] bound,
	output xrr_pkg::div_status_t        sts,
	output logic [xrr_pkg::DATA_W-1:0]  rem
);
	import xrr_pkg::*;

	logic                busy_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [DATA_W-1:0]   dividend_q;
	logic [BOUND_W-1:0]  r;
	logic [BOUND_W:0]    borrow;
	logic [BOUND_W-1:0]  shift;
	logic                take;

	// Chain of cells: remainder bits move up one place per step
	assign borrow[0] = 1'b1;
	assign shift[0]  = dividend_q[DATA_W-1];
	assign take      = ~borrow[BOUND_W];

	genvar i;
	generate
		for (i = 0; i < BOUND_W; i++) begin : g_cell
			if (i > 0) begin : g_link
				assign shift[i] = r[i-1];
			end
			xrr_cell u_cell (
				.clk       (clk),
				.load      (start),
				.step      (busy_q),
				.shift_in  (shift[i]),
				.bound_in  (bound[i]),
				.borrow_in (borrow[i]),
				.take      (take),
				.r         (r[i]),
				.borrow_out(borrow[i+1])
			);
		end
	endgenerate

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(DATA_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Dividend bits leave from the top
	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[DATA_W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q & (cnt_q == '0);
	assign rem      = r[DATA_W-1:0];

endmodule

// ===== tb/sv/xorshift32_ranged_random_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the ranged xorshift32 random source
// Writes seeds between phases and sends bounded requests with random idling
// on both sides. A local generator copy predicts every value, and each result
// is checked in order against the queue of expected values.
// ----------------------------------------------------------------------------
module xorshift32_ranged_random_tb;

	localparam int W              = xrr_pkg::DATA_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int REPORT_MAX     = 10;

	typedef logic signed [W-1:0] bound_t;
	typedef logic [W-1:0] word_t;

	localparam bound_t BOUND_MIN = {1'b1, {(W-1){1'b0}}};
	localparam bound_t BOUND_MAX = {1'b0, {(W-1){1'b1}}};

	// Bounds of one request with the value it must produce
	typedef struct {
		bound_t low;
		bound_t high;
		bound_t value;
	} draw_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_valid;
	logic   cfg_ready;
	word_t  seed;
	logic   in_valid;
	logic   in_stall;
	bound_t range_low;
	bound_t range_high;
	logic   out_valid;
	logic   out_stall;
	bound_t value;

	draw_t  expected_draws[$];
	word_t  gen_state;
	bit     no_idle;
	int     fail_count;
	int     requests_sent;
	int     empty_ranges;
	int     full_ranges;
	int     values_checked;
	int     seeds_loaded;
	int     idle_cycles;

	xorshift32_ranged_random dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed       (seed),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.range_low  (range_low),
		.range_high (range_high),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One generator step: left 13, right 17, left 5
	function automatic word_t xorshift_next(input word_t s);
		word_t a;
		word_t b;
		a = s ^ {s[W-14:0], 13'b0};
		b = a ^ {17'b0, a[W-1:17]};
		return b ^ {b[W-6:0], 5'b0};
	endfunction

	// Predict the value for one request and advance the local generator for a non-empty range
	function automatic bound_t predict_draw(input bound_t lo, input bound_t hi);
		longint unsigned span;
		longint unsigned rem;
		if (hi <= lo)
			return lo;
		gen_state = xorshift_next(gen_state);
		span = longint'(hi) - longint'(lo) + 1;
		rem = {32'b0, gen_state} % span;
		return lo + bound_t'(rem[W-1:0]);
	endfunction

	function automatic void report_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("ERROR: %s", msg);
	endfunction

	// Send one request; leave valid high so the next request can follow at once
	task automatic send_request(input bound_t lo, input bound_t hi);
		if (!no_idle && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		range_low  <= lo;
		range_high <= hi;
		do @(posedge clk); while (in_stall);
		expected_draws.push_back('{low: lo, high: hi, value: predict_draw(lo, hi)});
		requests_sent++;
		if (hi <= lo)
			empty_ranges++;
		if (lo == BOUND_MIN && hi == BOUND_MAX)
			full_ranges++;
	endtask

	// Load a seed once every outstanding value has come back
	task automatic write_seed(input word_t s);
		in_valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		seed      <= s;
		do @(posedge clk); while (!cfg_ready);
		gen_state = s;
		seeds_loaded++;
		cfg_valid <= 1'b0;
	endtask

	// Pick bounds, mostly non-empty, with a spread of span shapes
	task automatic pick_bounds(output bound_t lo, output bound_t hi);
		int k;
		lo = bound_t'($urandom);
		case ($urandom_range(0, 9))
			0: hi = bound_t'($urandom);
			1, 2, 3: hi = lo + bound_t'($urandom_range(1, 16));
			4: begin
				k  = $urandom_range(1, 31);
				hi = lo + ((bound_t'(1) <<< k) - 1);
			end
			5: begin
				lo = BOUND_MIN;
				hi = BOUND_MAX;
			end
			6: hi = lo;
			7: hi = lo - bound_t'($urandom_range(1, 1000));
			8: begin
				lo = BOUND_MIN + bound_t'($urandom_range(0, 7));
				hi = bound_t'($urandom);
			end
			default: begin
				lo = BOUND_MIN + bound_t'($urandom_range(0, 1000));
				hi = BOUND_MAX - bound_t'($urandom_range(0, 1000));
			end
		endcase
	endtask

	// Zero state out of reset: every request returns its lower bound
	task automatic test_zero_generator();
		send_request(0, 100);
		send_request(BOUND_MIN, BOUND_MAX);
		send_request(-5, 5);
		send_request(7, 7);
		send_request(BOUND_MAX, BOUND_MIN);
	endtask

	// Field extremes, empty ranges and the full range with an all-ones seed
	task automatic test_bound_extremes();
		write_seed('1);
		send_request(BOUND_MIN, BOUND_MAX);
		send_request(BOUND_MIN, BOUND_MAX);
		send_request(BOUND_MIN, BOUND_MIN);
		send_request(BOUND_MAX, BOUND_MAX);
		send_request(BOUND_MAX, BOUND_MIN);
		send_request(BOUND_MIN, BOUND_MIN + 1);
		send_request(BOUND_MAX - 1, BOUND_MAX);
		send_request(-1, 0);
		send_request(0, BOUND_MAX);
		send_request(BOUND_MIN, -1);
		send_request(BOUND_MIN + 1, BOUND_MAX);
		send_request(1, 0);
	endtask

	// Reloading the same seed repeats the sequence; a zero seed freezes it
	task automatic test_seed_reload();
		write_seed(32'h0000_0001);
		send_request(0, 100);
		send_request(-1000, 1000);
		write_seed(32'h0000_0001);
		send_request(0, 100);
		send_request(-1000, 1000);
		write_seed('0);
		send_request(0, 10);
		send_request(BOUND_MIN, BOUND_MAX);
	endtask

	task automatic test_random_ranges(input word_t s, input int count);
		bound_t lo;
		bound_t hi;
		write_seed(s);
		repeat (count) begin
			pick_bounds(lo, hi);
			send_request(lo, hi);
		end
	endtask

	// Last stretch: no idling on either side
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_random_ranges(word_t'($urandom), count);
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		seed       <= '0;
		in_valid   <= 1'b0;
		range_low  <= '0;
		range_high <= '0;
		no_idle    = 1'b0;
		gen_state  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_generator();
		test_bound_extremes();
		test_seed_reload();
		test_random_ranges(word_t'($urandom), 160);
		test_random_ranges('1, 160);
		test_random_ranges(32'h8000_0000, 160);
		test_random_ranges(word_t'($urandom), 160);
		test_random_ranges(word_t'($urandom), 160);
		test_back_to_back(60);

		// Drain outstanding values, then let the pipeline settle
		in_valid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d empty, %0d full range) over %0d seed loads",
			requests_sent, empty_ranges, full_ranges, seeds_loaded);
		$display("Checked %0d values, %0d failures", values_checked, fail_count);
		if (fail_count == 0 && expected_draws.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Result side: stall in random bursts until the final stretch
	initial begin
		out_stall <= 1'b0;
		forever begin
			if (no_idle) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Compare each accepted value with the oldest expectation
	always @(posedge clk) begin
		draw_t want;
		if (arst_n && out_valid && !out_stall) begin
			values_checked++;
			if (expected_draws.size() == 0) begin
				report_failure($sformatf("unexpected value %0d", value));
			end else begin
				want = expected_draws.pop_front();
				if (value !== want.value)
					report_failure($sformatf("value for [%0d, %0d]: expected %0d, got %0d",
						want.low, want.high, want.value, value));
			end
		end
	end

	// Stop the run when no channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		fail_count     = 0;
		requests_sent  = 0;
		empty_ranges   = 0;
		full_ranges    = 0;
		values_checked = 0;
		seeds_loaded   = 0;
		idle_cycles    = 0;
	end

endmodule

// ===== xorshift32_ranged_random.f =====
+incdir+design
design/xrr_pkg.sv
design/xrr_cell.sv
design/xrr_divider.sv
design/xorshift32_ranged_random.sv
tb/sv/xorshift32_ranged_random_tb.sv
